### rtl/wpf_pkg.sv
// wpf_pkg: shared types, codes and rounding helpers for the pcm sample to float block
// no dependencies

package wpf_pkg;

  localparam int unsigned RawW  = 64;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CfgW  = 16;

  localparam logic [CfgW-1:0] EncPcm   = 16'h0001;
  localparam logic [CfgW-1:0] EncFloat = 16'h0003;
  localparam logic [CfgW-1:0] EncExt   = 16'hFFFE;

  localparam logic [CfgW-1:0] RegEncoding = 16'd0;
  localparam logic [CfgW-1:0] RegBits     = 16'd1;

  localparam logic [CfgW-1:0] EncReset  = EncPcm;
  localparam logic [CfgW-1:0] BitsReset = 16'd16;

  localparam logic [30:0] F32Inf = 31'h7F80_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ENC   = 2'd1,
    ST_BAD_DEPTH = 2'd2
  } status_e;

  // leading zero count, zero input gives zero
  function automatic logic [4:0] lzc32(logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // magnitude scaled by 2^-(n-1), n in 8..32, magnitude up to 2^31
  function automatic logic [30:0] int_mag_bits(logic [31:0] mag, logic [5:0] n);
    logic [4:0]  lz;
    logic [31:0] norm;
    logic [8:0]  expb;
    logic        up;
    logic [24:0] m;
    lz   = lzc32(mag);
    norm = mag << lz;
    up   = norm[7] & ((|norm[6:0]) | norm[8]);
    m    = {1'b0, norm[31:8]} + 25'(up);
    expb = 9'd158 - 9'(lz) - 9'(n);
    if (mag == '0) return '0;
    return {expb[7:0], 23'b0} + 31'(m);
  endfunction

  // double to single magnitude bits, finite inputs only
  function automatic logic [30:0] dbl_mag_bits(logic [10:0] e, logic [51:0] frac);
    logic [10:0]  eeff;
    logic [11:0]  dsh;
    logic [6:0]   sh;
    logic [7:0]   expb;
    logic [63:0]  sig;
    logic [127:0] wide;
    logic         up;
    logic [24:0]  m;
    eeff = (e == '0) ? 11'd1 : e;
    dsh  = 12'd926 - 12'(eeff);
    if (eeff >= 11'd897) sh = 7'd29;
    else if (dsh > 12'd64) sh = 7'd64;
    else sh = dsh[6:0];
    expb = (e >= 11'd897) ? 8'(e - 11'd897) : 8'd0;
    sig  = {11'b0, (e != '0), frac};
    wide = {sig, 64'b0} >> sh;
    up   = wide[63] & ((|wide[62:0]) | wide[64]);
    m    = wide[88:64] + 25'(up);
    if (e >= 11'd1151) return F32Inf;
    return {expb, 23'b0} + 31'(m);
  endfunction

endpackage

### rtl/wpf_if.sv
// wpf channel interfaces: sample input, result output and register write
// depends on wpf_pkg

interface wpf_in_if;
  logic                      valid;
  logic                      ready;
  logic [wpf_pkg::RawW-1:0]  sample_bytes;
  modport source (output valid, output sample_bytes, input ready);
  modport sink   (input valid, input sample_bytes, output ready);
endinterface

interface wpf_out_if;
  logic                      valid;
  logic                      ready;
  logic [wpf_pkg::ValW-1:0]  value_bits;
  logic [1:0]                status;
  modport source (output valid, output value_bits, output status, input ready);
  modport sink   (input valid, input value_bits, input status, output ready);
endinterface

interface wpf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wpf_pkg::CfgW-1:0]  index;
  logic [wpf_pkg::CfgW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wav_pcm_sample_to_float_top.sv
// Converts raw little-endian wav sample words to single-precision floats, one word per
// cycle while the output is not stalled: an input register feeds the converter, whose
// result is held in an output register. Stalls on the output ripple back to the input
// ready. Registers (0 encoding, 1 bits per sample) are written through the cfg channel.
// top level, depends on wpf_pkg, wpf_if and wpf_conv

module wav_pcm_sample_to_float_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpf_in_if.sink    sample_i,
  wpf_out_if.source result_o,
  wpf_cfg_if.sink   cfg_i
);
  import wpf_pkg::*;

  logic [CfgW-1:0] enc_q, bits_q;
  logic            s1_valid_q, out_valid_q;
  logic [RawW-1:0] raw_q;
  logic [ValW-1:0] val_d, val_q;
  status_e         st_d, st_q;
  logic            out_adv, s1_adv;

  assign out_adv        = !out_valid_q || result_o.ready;
  assign s1_adv         = !s1_valid_q || out_adv;
  assign sample_i.ready = s1_adv;
  assign cfg_i.ready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q  <= EncReset;
      bits_q <= BitsReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegEncoding) enc_q <= cfg_i.data;
      if (cfg_i.index == RegBits) bits_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= sample_i.valid;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && sample_i.valid) raw_q <= sample_i.sample_bytes;
    if (out_adv && s1_valid_q) begin
      val_q <= val_d;
      st_q  <= st_d;
    end
  end

  wpf_conv u_conv (
    .encoding_i (enc_q),
    .bits_i     (bits_q),
    .raw_i      (raw_q),
    .value_o    (val_d),
    .status_o   (st_d)
  );

  assign result_o.valid      = out_valid_q;
  assign result_o.value_bits = val_q;
  assign result_o.status     = st_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q != ST_OK |-> val_q == '0) else $error("error word not zero");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(raw_q)) else $error("stage lost");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv |=> out_valid_q) else $error("word dropped");
`endif

endmodule

### rtl/wpf_conv.sv
// wpf_conv: combinational conversion of one raw sample word to single precision
// depends on wpf_pkg

module wpf_conv (
  input  logic [wpf_pkg::CfgW-1:0] encoding_i,
  input  logic [wpf_pkg::CfgW-1:0] bits_i,
  input  logic [wpf_pkg::RawW-1:0] raw_i,
  output logic [wpf_pkg::ValW-1:0] value_o,
  output wpf_pkg::status_e         status_o
);
  import wpf_pkg::*;

  logic        is_float, is_int;
  logic [7:0]  b8;
  logic [31:0] mag8, mag16, mag24, mag32;
  logic [32:0] neg32;
  logic [10:0] de;
  logic [51:0] df;

  assign is_float = (encoding_i == EncFloat);
  assign is_int   = (encoding_i == EncPcm) || (encoding_i == EncExt);
  assign b8       = raw_i[7:0];
  assign mag8     = b8[7] ? 32'({1'b0, b8[6:0]}) : 32'(8'd128 - b8);
  assign mag16    = raw_i[15] ? 32'(17'h10000 - 17'(raw_i[15:0])) : 32'(raw_i[15:0]);
  assign mag24    = raw_i[23] ? 32'(25'h1000000 - 25'(raw_i[23:0])) : 32'(raw_i[23:0]);
  assign neg32    = 33'h1_0000_0000 - 33'(raw_i[31:0]);
  assign mag32    = raw_i[31] ? neg32[31:0] : raw_i[31:0];
  assign de       = raw_i[62:52];
  assign df       = raw_i[51:0];

  always_comb begin
    value_o  = '0;
    status_o = ST_OK;
    priority if (is_float && bits_i == 16'd32) begin
      value_o = raw_i[31:0];
    end else if (is_float && bits_i == 16'd64) begin
      if (de == 11'h7FF) begin
        value_o = (df == '0) ? {raw_i[63], F32Inf}
                             : {raw_i[63], F32Inf | 31'h0040_0000 | 31'(df[51:29])};
      end else begin
        value_o = {raw_i[63], dbl_mag_bits(de, df)};
      end
    end else if (!is_int) begin
      status_o = ST_BAD_ENC;
    end else if (bits_i == 16'd8) begin
      value_o = {~b8[7], int_mag_bits(mag8, 6'd8)};
    end else if (bits_i == 16'd16) begin
      value_o = {raw_i[15], int_mag_bits(mag16, 6'd16)};
    end else if (bits_i == 16'd24) begin
      value_o = {raw_i[23], int_mag_bits(mag24, 6'd24)};
    end else if (bits_i == 16'd32) begin
      value_o = {raw_i[31], int_mag_bits(mag32, 6'd32)};
    end else begin
      status_o = ST_BAD_DEPTH;
    end
  end

endmodule

### tb/testbench.sv
// testbench for wav_pcm_sample_to_float_top: drives sample words and register writes,
// predicts each converted value and checks it against the block output
// depends on wpf_pkg, wpf_if and the rtl of the block

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpf_pkg::*;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [1:0]  status;
  } conv_res_t;

  logic clk_i;
  logic rst_ni;

  wpf_in_if  sample_ch ();
  wpf_out_if result_ch ();
  wpf_cfg_if cfg_ch ();

  wav_pcm_sample_to_float_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch.sink),
    .result_o (result_ch.source),
    .cfg_i    (cfg_ch.sink)
  );

  logic [15:0] cur_enc;
  logic [15:0] cur_bits;
  logic [63:0] word_q[$];
  conv_res_t   expected_q[$];
  int          errors;
  int          results_seen;
  int          words_sent;
  bit          quiet;
  bit          long_hold;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void add_word(logic [63:0] w);
    word_q.insert(word_q.size(), w);
  endfunction

  function automatic logic [31:0] pack_f32(logic sgn, logic [63:0] mag, int exp2);
    int          top;
    int          shift;
    int          q;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    if (mag == 64'd0) return {sgn, 31'd0};
    top = 0;
    while (top < 63 && (mag >> (top + 1)) != 64'd0) top++;
    shift = top - 23;
    if (-149 - exp2 > shift) shift = -149 - exp2;
    if (shift <= 0) begin
      m = mag << (-shift);
    end else if (shift > 63) begin
      m = 64'd0;
    end else begin
      rem  = mag & ((64'd1 << shift) - 64'd1);
      half = 64'd1 << (shift - 1);
      m    = mag >> shift;
      if (rem > half || (rem == half && m[0])) m++;
    end
    q = exp2 + shift;
    bits = (64'(q + 149) << 23) + m;
    if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [10:0] e;
    logic [51:0] frac;
    e    = d[62:52];
    frac = d[51:0];
    if (e == 11'h7FF) begin
      if (frac == 52'd0) return {d[63], 31'h7F80_0000};
      return {d[63], 31'h7F80_0000} | 32'h0040_0000 | 32'(frac >> 29);
    end
    if (e == 11'd0) return pack_f32(d[63], {12'd0, frac}, -1074);
    return pack_f32(d[63], {11'd0, 1'b1, frac}, int'(e) - 1075);
  endfunction

  function automatic logic [31:0] scale_signed(logic [63:0] v, int n);
    logic [63:0] msk;
    logic [63:0] sb;
    logic [63:0] mag;
    msk = (64'd1 << n) - 64'd1;
    sb  = 64'd1 << (n - 1);
    v   = v & msk;
    if ((v & sb) != 0) begin
      mag = (~v + 64'd1) & msk;
      if (mag == 0) mag = sb;
      return pack_f32(1'b1, mag, -(n - 1));
    end
    return pack_f32(1'b0, v, -(n - 1));
  endfunction

  function automatic conv_res_t convert_sample(logic [63:0] raw);
    conv_res_t r;
    r.value_bits = 32'd0;
    r.status     = ST_OK;
    if (cur_enc == EncFloat && cur_bits == 16'd32) begin
      r.value_bits = raw[31:0];
    end else if (cur_enc == EncFloat && cur_bits == 16'd64) begin
      r.value_bits = narrow_double(raw);
    end else if (cur_enc != EncPcm && cur_enc != EncExt) begin
      r.status = ST_BAD_ENC;
    end else if (cur_bits == 16'd8) begin
      if (raw[7]) r.value_bits = pack_f32(1'b0, 64'(raw[7:0]) - 64'd128, -7);
      else r.value_bits = pack_f32(1'b1, 64'd128 - 64'(raw[7:0]), -7);
    end else if (cur_bits == 16'd16) begin
      r.value_bits = scale_signed(raw, 16);
    end else if (cur_bits == 16'd24) begin
      r.value_bits = scale_signed(raw, 24);
    end else if (cur_bits == 16'd32) begin
      r.value_bits = scale_signed(raw, 32);
    end else begin
      r.status = ST_BAD_DEPTH;
    end
    return r;
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid        <= 1'b0;
      sample_ch.sample_bytes <= '0;
      send_gap               <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_q.insert(expected_q.size(), convert_sample(sample_ch.sample_bytes));
        words_sent++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap > 0) begin
          send_gap        <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap        <= $urandom_range(1, 18);
          sample_ch.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          sample_ch.valid        <= 1'b1;
          sample_ch.sample_bytes <= word_q.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      recv_gap        <= 0;
      hold_cnt        <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: value %h status %0d",
                                     result_ch.value_bits, result_ch.status);
        end else begin
          conv_res_t exp_r;
          exp_r = expected_q.pop_front();
          if (exp_r.value_bits !== result_ch.value_bits || exp_r.status !== result_ch.status)
          begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       exp_r.value_bits, exp_r.status, result_ch.value_bits,
                       result_ch.status);
          end
        end
      end
      if (long_hold && hold_cnt == 0) begin
        hold_cnt        <= 200;
        result_ch.ready <= 1'b0;
      end else if (hold_cnt > 1) begin
        hold_cnt        <= hold_cnt - 1;
        result_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap        <= recv_gap - 1;
        result_ch.ready <= (recv_gap == 1);
        hold_cnt        <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap        <= $urandom_range(1, 18);
        result_ch.ready <= 1'b0;
        hold_cnt        <= 0;
      end else begin
        result_ch.ready <= 1'b1;
        hold_cnt        <= 0;
      end
    end
  end

  task automatic write_reg(logic [15:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == RegEncoding) cur_enc = val;
    else cur_bits = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (word_q.size() > 0 || sample_ch.valid || expected_q.size() > 0);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [15:0] enc, logic [15:0] bits);
    drain();
    write_reg(RegEncoding, enc);
    write_reg(RegBits, bits);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // doubles biased towards the single range edges, special values and rounding ties
  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    d = rand64();
    case ($urandom_range(0, 5))
      0: d[62:52] = 11'($urandom_range(1023 - 160, 1023 - 120));
      1: d[62:52] = 11'($urandom_range(1023 + 120, 1023 + 130));
      2: d[62:52] = 11'($urandom_range(1023 - 40, 1023 + 40));
      3: d[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      4: d[28:0]  = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h0;
      default: ;
    endcase
    return d;
  endfunction

  typedef struct {
    logic [15:0] enc;
    logic [15:0] bits;
  } mode_t;

  initial begin
    mode_t modes[$];
    mode_t md;
    rst_ni         = 1'b0;
    quiet          = 1'b0;
    long_hold      = 1'b0;
    errors         = 0;
    results_seen   = 0;
    words_sent     = 0;
    cur_enc        = EncReset;
    cur_bits       = BitsReset;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 16 bit pcm
    add_word(64'h0);
    add_word(64'h8000);
    add_word(64'h7FFF);
    add_word(64'hFFFF_FFFF_FFFF_FFFF);
    set_mode(EncPcm, 16'd8);
    add_word(64'h00); add_word(64'h80);
    add_word(64'hFF); add_word(64'hFFFF_FFFF_FFFF_FF7F);
    set_mode(EncExt, 16'd24);
    add_word(64'h80_0000); add_word(64'h7F_FFFF);
    set_mode(EncPcm, 16'd32);
    add_word(64'h8000_0000); add_word(64'h7FFF_FFFF);
    add_word(64'h0000_0001); add_word(64'h0000_0180);
    set_mode(EncFloat, 16'd64);
    add_word(64'h8000_0000_0000_0000);
    add_word(64'h7FF0_0000_0000_0000);
    add_word(64'hFFF8_0000_0000_0001);
    add_word(64'h7FEF_FFFF_FFFF_FFFF);
    add_word(64'h3690_0000_0000_0000);
    add_word(64'h3FF0_0000_1000_0000);
    set_mode(EncFloat, 16'd16);
    add_word(64'h1234);
    set_mode(EncPcm, 16'd64);
    add_word(64'h1234);
    set_mode(16'hFFFF, 16'hFFFF);
    add_word(rand64());
    set_mode(EncFloat, 16'd32);
    add_word(64'hFFFF_FFFF_7FC0_0001);

    modes = '{'{EncPcm, 16'd8}, '{EncPcm, 16'd16}, '{EncExt, 16'd24},
              '{EncPcm, 16'd32}, '{EncExt, 16'd32}, '{EncFloat, 16'd32},
              '{EncFloat, 16'd64}, '{EncFloat, 16'd64}, '{EncExt, 16'd0},
              '{16'd0, 16'd16}, '{16'd2, 16'd64}};
    for (int ph = 0; ph < 18; ph++) begin
      md = modes[$urandom_range(0, modes.size() - 1)];
      if (ph == 17) md = '{EncFloat, 16'd64};
      if ($urandom_range(0, 7) == 0) md.bits = 16'($urandom());
      set_mode(md.enc, md.bits);
      if (ph == 5) long_hold = 1'b1;
      if (ph == 16) quiet = 1'b1;
      for (int k = 0; k < 104; k++)
        add_word((md.enc == EncFloat && md.bits == 16'd64) ? rand_double() : rand64());
      if (ph == 5) begin
        while (word_q.size() > 90) @(posedge clk_i);
        long_hold = 1'b0;
      end
    end
    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d sample words over pcm, extensible, float and bad settings",
             words_sent);
    $display("checked %0d converted words, %0d mismatches", results_seen, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
